// ===== rtl/sefr_pkg.sv =====
// ----------------------------------------------------------------------------
// sefr_pkg: shared types and constants of the delimited frame receiver
// Frame store sizing, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package sefr_pkg;

	localparam int FRAME_CAPACITY = 64;
	localparam int ADDR_W         = $clog2(FRAME_CAPACITY);
	localparam int CNT_W          = $clog2(FRAME_CAPACITY + 1);
	localparam int LENGTH_POS     = 2;

	localparam logic [7:0] START_CODE_RESET = 8'h01;
	localparam logic [7:0] END_CODE_RESET   = 8'h04;

	localparam logic REG_START_CODE = 1'b0;
	localparam logic REG_END_CODE   = 1'b1;

	typedef enum logic [1:0] {
		ST_WAIT,
		ST_FRAME,
		ST_FETCH,
		ST_SHOW
	} state_t;

endpackage

// ===== rtl/sefr_ram.sv =====
// ----------------------------------------------------------------------------
// sefr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sefr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/soh_eot_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// soh_eot_frame_receiver: start/end delimited frame receiver with length byte
// Collects bytes between start and end codes, checks the length byte and
// replays accepted frames from the frame store.
// ----------------------------------------------------------------------------
// Sequencing: after the end code word of an accepted frame is taken, the
//   store is read in ST_FETCH and the frame starts to leave in ST_SHOW.
// Throughput: one input word per cycle while receiving; replay reads each
//   frame byte from the store, then outputs it, input held off meanwhile.
// Reset: arst_n clears the sequencer and sets start_code to 1, end_code to 4.
module soh_eot_frame_receiver
	import sefr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;

	logic [7:0]       start_code_q;
	logic [7:0]       end_code_q;
	logic [CNT_W-1:0] fill_count_q;
	logic             overflowed_q;
	logic [7:0]       length_q;
	logic [CNT_W-1:0] rd_idx_q;

	logic             in_acc;
	logic             out_acc;
	logic             cfg_wr;
	logic             is_start;
	logic             is_end;
	logic             has_room;
	logic [CNT_W-1:0] total;
	logic             frame_ok;
	logic             rd_last;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_re;
	logic [7:0]        ram_rdata;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = {24'd0, (paddr[2] == REG_END_CODE) ? end_code_q : start_code_q};

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_acc  = m_axis_tvalid && m_axis_tready;
	assign is_start = (s_axis_tdata == start_code_q);
	assign is_end   = (s_axis_tdata == end_code_q);
	assign has_room = (fill_count_q < CNT_W'(FRAME_CAPACITY - 1));
	assign total    = fill_count_q + CNT_W'(1);
	assign frame_ok = !overflowed_q
		&& (fill_count_q > CNT_W'(LENGTH_POS))
		&& (fill_count_q < CNT_W'(FRAME_CAPACITY))
		&& (length_q == 8'(total));
	assign rd_last  = (rd_idx_q == fill_count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_WAIT: begin
				if (in_acc && is_start) begin
					state_d = ST_FRAME;
				end
			end
			ST_FRAME: begin
				if (in_acc && is_end) begin
					state_d = frame_ok ? ST_FETCH : ST_WAIT;
				end
			end
			ST_FETCH: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_acc) begin
					state_d = rd_last ? ST_WAIT : ST_FETCH;
				end
			end
			default: begin
				state_d = ST_WAIT;
			end
		endcase
	end

	// outputs and store control
	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = fill_count_q[ADDR_W-1:0];
		ram_re        = 1'b0;
		case (state_q)
			ST_WAIT: begin
				s_axis_tready = 1'b1;
				ram_we        = in_acc && is_start;
				ram_waddr     = '0;
			end
			ST_FRAME: begin
				s_axis_tready = 1'b1;
				ram_we        = in_acc && (is_end ? frame_ok : has_room);
			end
			ST_FETCH: begin
				ram_re = 1'b1;
			end
			ST_SHOW: begin
				m_axis_tvalid = 1'b1;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	assign m_axis_tdata = ram_rdata;
	assign m_axis_tlast = rd_last;

	sefr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_axis_tdata),
		.re    (ram_re),
		.raddr (rd_idx_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_WAIT;
			start_code_q <= START_CODE_RESET;
			end_code_q   <= END_CODE_RESET;
			fill_count_q <= CNT_W'(1);
			overflowed_q <= 1'b0;
			rd_idx_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				if (paddr[2] == REG_START_CODE) begin
					start_code_q <= pwdata[7:0];
				end else begin
					end_code_q <= pwdata[7:0];
				end
			end
			case (state_q)
				ST_WAIT: begin
					fill_count_q <= CNT_W'(1);
					overflowed_q <= 1'b0;
					rd_idx_q     <= '0;
				end
				ST_FRAME: begin
					if (in_acc && !is_end) begin
						if (has_room) begin
							fill_count_q <= total;
						end else begin
							overflowed_q <= 1'b1;
						end
					end
				end
				ST_SHOW: begin
					if (out_acc) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
				end
				default: begin
					rd_idx_q <= rd_idx_q;
				end
			endcase
		end
	end

	// hold the length byte as it is stored
	always_ff @(posedge clk) begin
		if (state_q == ST_FRAME && in_acc && !is_end
			&& fill_count_q == CNT_W'(LENGTH_POS)) begin
			length_q <= s_axis_tdata;
		end
	end

endmodule

// ===== test/tb_soh_eot_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_soh_eot_frame_receiver: self-checking bench for the delimited frame receiver
// Streams well-formed, short, mislabeled, oversized and idle-line byte runs
// through the receiver under several start/end code settings and idling
// patterns, predicts the replayed frames and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_soh_eot_frame_receiver;
	import sefr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 35;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;           // [7:0] frame_byte
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	logic [7:0]  rx_pending [$];
	frame_word_t frame_expected [$];
	frame_word_t exp_word;

	logic [7:0]  cfg_start = START_CODE_RESET;
	logic [7:0]  cfg_end = END_CODE_RESET;

	logic             rcv_in_frame = 1'b0;
	logic [CNT_W-1:0] rcv_fill = CNT_W'(1);
	logic             rcv_overflow = 1'b0;
	logic [7:0]       rcv_store [FRAME_CAPACITY];

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;

	logic        nxt_valid;
	logic [7:0]  nxt_data;

	soh_eot_frame_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[soh_eot_frame_receiver] ERROR");
			$finish;
		end
	end

	task automatic receive_byte(input logic [7:0] b);
		int k;
		if (!rcv_in_frame) begin
			if (b == cfg_start) begin
				rcv_store[0] = b;
				rcv_in_frame = 1'b1;
				rcv_fill = CNT_W'(1);
				rcv_overflow = 1'b0;
			end
		end else if (b == cfg_end) begin
			if (!rcv_overflow && rcv_fill > LENGTH_POS && rcv_fill < FRAME_CAPACITY &&
					rcv_store[LENGTH_POS] == rcv_fill + 1) begin
				rcv_store[rcv_fill] = b;
				for (k = 0; k <= rcv_fill; k++)
					frame_expected.push_back('{rcv_store[k], k == rcv_fill});
			end
			rcv_in_frame = 1'b0;
			rcv_fill = CNT_W'(1);
			rcv_overflow = 1'b0;
		end else if (rcv_fill < FRAME_CAPACITY - 1) begin
			rcv_store[rcv_fill] = b;
			rcv_fill = rcv_fill + CNT_W'(1);
		end else begin
			rcv_overflow = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'd0;
		end else begin
			nxt_valid = s_axis_tvalid;
			nxt_data = s_axis_tdata;
			if (s_axis_tvalid && s_axis_tready) begin
				receive_byte(s_axis_tdata);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && rx_pending.size() > 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				nxt_data = rx_pending.pop_front();
				nxt_valid = 1'b1;
			end
			s_axis_tvalid <= nxt_valid;
			s_axis_tdata <= nxt_data;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (frame_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected frame word %02h last %0b",
							m_axis_tdata, m_axis_tlast);
				end else begin
					exp_word = frame_expected.pop_front();
					if (m_axis_tdata !== exp_word.data || m_axis_tlast !== exp_word.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("frame word mismatch: expected %02h last %0b, got %02h last %0b",
								exp_word.data, exp_word.last, m_axis_tdata, m_axis_tlast);
					end
				end
			end
			m_axis_tready <= $urandom_range(0, 99) >= stall_pct;
		end
	end

	task automatic reg_write(input logic idx, input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_START_CODE)
			cfg_start = val;
		else
			cfg_end = val;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (rx_pending.size() != 0 || s_axis_tvalid || frame_expected.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == cfg_end);
		return b;
	endfunction

	function automatic int frame_len();
		int len;
		if ($urandom_range(0, 19) == 0)
			len = $urandom_range(56, FRAME_CAPACITY);
		else
			len = $urandom_range(4, 14);
		if (len == cfg_end)
			len = (len == FRAME_CAPACITY) ? len - 1 : len + 1;
		return len;
	endfunction

	task automatic push_sequence(output int n);
		logic [7:0] seq [$];
		logic [7:0] lb;
		int kind;
		int len;
		int k;
		kind = $urandom_range(0, 99);
		if (kind < 72) begin
			len = frame_len();
			lb = 8'(len);
			if (kind >= 60)
				do lb = 8'($urandom_range(0, 255)); while (lb == len || lb == cfg_end);
			seq.push_back(cfg_start);
			seq.push_back(body_byte());
			seq.push_back(lb);
			for (k = 0; k < len - 4; k++)
				seq.push_back(body_byte());
			seq.push_back(cfg_end);
		end else if (kind < 82) begin
			seq.push_back(cfg_start);
			for (k = $urandom_range(0, 1); k > 0; k--)
				seq.push_back(body_byte());
			seq.push_back(cfg_end);
		end else if (kind < 85) begin
			seq.push_back(cfg_start);
			for (k = $urandom_range(63, 68); k > 0; k--)
				seq.push_back(body_byte());
			seq.push_back(cfg_end);
		end else begin
			for (k = $urandom_range(1, 3); k > 0; k--) begin
				do lb = 8'($urandom_range(0, 255)); while (lb == cfg_start || lb == cfg_end);
				seq.push_back(lb);
			end
		end
		n = seq.size();
		foreach (seq[i])
			rx_pending.push_back(seq[i]);
	endtask

	initial begin
		int p;
		int cnt;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		rx_pending = '{8'hFF, 8'h00,
			8'h01, 8'h04,
			8'h01, 8'h00, 8'h04,
			8'h01, 8'hFF, 8'h05, 8'h00, 8'h04,
			8'h01, 8'h01, 8'h06, 8'h01, 8'hFF, 8'h04,
			8'h01, 8'h00, 8'h09, 8'h04};
		wait_drained();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin
					reg_write(REG_START_CODE, 8'h00);
					reg_write(REG_END_CODE, 8'hFF);
				end
				1: begin
					reg_write(REG_START_CODE, 8'hFF);
					reg_write(REG_END_CODE, 8'h00);
				end
				2: begin
					reg_write(REG_START_CODE, 8'h7E);
					reg_write(REG_END_CODE, 8'h7E);
				end
				3: begin
					reg_write(REG_START_CODE, START_CODE_RESET);
					reg_write(REG_END_CODE, END_CODE_RESET);
				end
				default: begin
					reg_write(REG_START_CODE, 8'($urandom_range(0, 255)));
					reg_write(REG_END_CODE, 8'($urandom_range(0, 255)));
				end
			endcase
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 62;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 62;
				end
				default: begin
					send_idle_pct = 11;
					stall_pct = 11;
				end
			endcase
			cnt = 0;
			while (cnt < PHASE_WORDS) begin
				push_sequence(n);
				cnt += n;
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && frame_expected.size() == 0)
			$display("[soh_eot_frame_receiver] OK");
		else
			$display("[soh_eot_frame_receiver] ERROR");
		$finish;
	end

endmodule
